// File: sv/msmix_pkg.sv
// Shared constants, types and the state encoding of the audio mix ring.
package msmix_pkg;

  localparam int SOURCES      = 6;
  localparam int NUM_RATE     = 6;
  localparam int RING_DEPTH   = 65536;
  localparam int RING_AW      = $clog2(RING_DEPTH);
  localparam int LEAD_FRAMES  = 1024;
  localparam int GUARD_FRAMES = 4096;

  localparam int SRC_W     = 3;
  localparam int SRC_IDX_W = $clog2(NUM_RATE);
  localparam int SAMPLE_W  = 16;
  localparam int GAIN_W    = 16;
  localparam int STEP_W    = 24;
  localparam int PHASE_W   = 16;
  localparam int CNT_W     = STEP_W - PHASE_W + 1;
  localparam int POS_W     = 64;
  localparam int ACC_W     = 32;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DW    = 24;

  localparam logic [CFG_IDX_W-1:0] CFG_MUTED = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_GAIN  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_RATE0 = 3'd2;

  localparam logic [GAIN_W-1:0] GAIN_RESET = 16'd32768;
  localparam logic [STEP_W-1:0] STEP_RESET = 24'd65536;

  typedef logic [RING_AW-1:0] ring_addr_t;

  typedef struct packed {
    logic [ACC_W-1:0] right;
    logic [ACC_W-1:0] left;
  } slot_t;

  typedef struct packed {
    logic       rd_en;
    ring_addr_t rd_addr;
    logic       wr_en;
    ring_addr_t wr_addr;
    slot_t      wr_data;
  } ring_req_t;

  typedef enum logic [5:0] {
    ST_IDLE   = 6'b000001,
    ST_CHECK  = 6'b000010,
    ST_STEP   = 6'b000100,
    ST_MIX    = 6'b001000,
    ST_DR_CLR = 6'b010000,
    ST_DR_OUT = 6'b100000
  } state_e;

endpackage

// File: sv/msmix_ring.sv
// Accumulator ring memory with one read and one write port and a clearing pass after reset.
module msmix_ring import msmix_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  ring_req_t req_i,
  output slot_t     rd_data_o,
  output logic      ready_o
);

  slot_t            mem_q [RING_DEPTH];
  slot_t            rd_data_q;
  logic [RING_AW:0] clr_cnt_q;
  logic             clearing;

  assign clearing = !clr_cnt_q[RING_AW];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_cnt_q <= '0;
    end else if (clearing) begin
      clr_cnt_q <= clr_cnt_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (clearing) begin
      mem_q[clr_cnt_q[RING_AW-1:0]] <= '0;
    end else if (req_i.wr_en) begin
      mem_q[req_i.wr_addr] <= req_i.wr_data;
    end
    if (req_i.rd_en) begin
      rd_data_q <= mem_q[req_i.rd_addr];
    end
  end

  assign rd_data_o = rd_data_q;
  assign ready_o   = !clearing;

endmodule

// File: sv/msmix_scale.sv
// Two-stage gain scaler: sample * gain * 32767 / 2^30, truncated toward zero.
module msmix_scale import msmix_pkg::*; (
  input  logic                       clk_i,
  input  logic                       muted_i,
  input  logic        [GAIN_W-1:0]   gain_i,
  input  logic signed [SAMPLE_W-1:0] left_i,
  input  logic signed [SAMPLE_W-1:0] right_i,
  output logic        [ACC_W-1:0]    add_left_o,
  output logic        [ACC_W-1:0]    add_right_o
);

  localparam int GK_W  = GAIN_W + 15;
  localparam int MAG_W = SAMPLE_W + GK_W;
  localparam int Q_W   = MAG_W - 30;

  logic [GAIN_W-1:0]   gain_eff;
  logic [GK_W-1:0]     gk_d, gk_q;
  logic [SAMPLE_W-1:0] abs_l, abs_r;
  logic [MAG_W-1:0]    mag_l_q, mag_r_q;
  logic                neg_l_q, neg_r_q;
  logic [Q_W-1:0]      q_l, q_r;
  logic [ACC_W-1:0]    add_l_q, add_r_q;

  // g * 32767 as (g << 15) - g
  assign gain_eff = muted_i ? '0 : gain_i;
  assign gk_d     = {gain_eff, 15'b0} - {15'b0, gain_eff};

  assign abs_l = left_i[SAMPLE_W-1]  ? SAMPLE_W'(-left_i)  : SAMPLE_W'(left_i);
  assign abs_r = right_i[SAMPLE_W-1] ? SAMPLE_W'(-right_i) : SAMPLE_W'(right_i);

  assign q_l = mag_l_q[MAG_W-1:30];
  assign q_r = mag_r_q[MAG_W-1:30];

  always_ff @(posedge clk_i) begin
    gk_q    <= gk_d;
    mag_l_q <= {{GK_W{1'b0}}, abs_l} * {{SAMPLE_W{1'b0}}, gk_q};
    mag_r_q <= {{GK_W{1'b0}}, abs_r} * {{SAMPLE_W{1'b0}}, gk_q};
    neg_l_q <= left_i[SAMPLE_W-1];
    neg_r_q <= right_i[SAMPLE_W-1];
    add_l_q <= neg_l_q ? ACC_W'(-{{(ACC_W-Q_W){1'b0}}, q_l}) : {{(ACC_W-Q_W){1'b0}}, q_l};
    add_r_q <= neg_r_q ? ACC_W'(-{{(ACC_W-Q_W){1'b0}}, q_r}) : {{(ACC_W-Q_W){1'b0}}, q_r};
  end

  assign add_left_o  = add_l_q;
  assign add_right_o = add_r_q;

endmodule

// File: sv/multi_source_audio_mix_ring.sv
// Top level of the multi-source audio mix ring: control, source state and configuration.
//
// Input channel (in_valid_i/in_ready_o) carries one request: kind_i = 0 pushes a
// stereo frame for source_id_i, kind_i = 1 drains one output frame. A drain gives
// one result on the output channel (out_valid_o/out_ready_i); a push gives none.
// Requests are handled one at a time. A drain clears its slot in ST_DR_CLR and
// loads the output register there or, once it is free, in ST_DR_OUT. A push
// ends in ST_CHECK for an unknown source; else it passes ST_STEP and writes N
// ring slots in ST_MIX (N is 0 to 256, from the source phase plus its rate
// step); the ring memory is pipelined read-add-write at one slot per cycle.
// A finished drain result waits in the output register; further pushes are taken
// meanwhile, and a following drain waits only for that register to empty.
// After reset the ring is cleared one slot per cycle with in_ready_o low, while
// configuration writes are taken. Configuration is written through cfg_we_i/
// cfg_idx_i/cfg_wdata_i by the user while no request is in flight, unchecked.
module multi_source_audio_mix_ring import msmix_pkg::*; (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic        [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic        [CFG_DW-1:0]   cfg_wdata_i,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic                       kind_i,
  input  logic        [SRC_W-1:0]    source_id_i,
  input  logic                       first_of_buffer_i,
  input  logic signed [SAMPLE_W-1:0] left_in_i,
  input  logic signed [SAMPLE_W-1:0] right_in_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic signed [SAMPLE_W-1:0] left_out_o,
  output logic signed [SAMPLE_W-1:0] right_out_o
);

  function automatic logic [SAMPLE_W-1:0] sat16(input logic [ACC_W-1:0] acc);
    logic [SAMPLE_W-1:0] r;
    if (acc[ACC_W-1] && !(&acc[ACC_W-2:SAMPLE_W-1])) begin
      r = {1'b1, {(SAMPLE_W-1){1'b0}}};
    end else if (!acc[ACC_W-1] && (|acc[ACC_W-2:SAMPLE_W-1])) begin
      r = {1'b0, {(SAMPLE_W-1){1'b1}}};
    end else begin
      r = acc[SAMPLE_W-1:0];
    end
    return r;
  endfunction

  state_e state_d, state_q;

  logic              muted_q;
  logic [GAIN_W-1:0] gain_q;
  logic [STEP_W-1:0] rate_q [NUM_RATE];

  logic [POS_W-1:0]   pos_q   [SOURCES];
  logic [PHASE_W-1:0] phase_q [SOURCES];
  logic [POS_W-1:0]   rp_d, rp_q, bound_d, bound_q, lead_d, lead_q;

  logic [SRC_W-1:0]          src_q;
  logic                      fob_q;
  logic signed [SAMPLE_W-1:0] left_q, right_q;
  logic [POS_W-1:0]          cur_pos_d, cur_pos_q;
  logic [PHASE_W-1:0]        cur_phase_d, cur_phase_q;
  logic [CNT_W-1:0]          cnt_d, cnt_q;
  logic                      wr_pend_d, wr_pend_q;
  ring_addr_t                wr_addr_d, wr_addr_q;
  logic                      out_vld_d, out_vld_q;
  logic [SAMPLE_W-1:0]       out_l_q, out_r_q;
  logic                      out_load;

  logic [SRC_IDX_W-1:0]      idx;
  logic                      relocate;
  logic [STEP_W:0]           step_sum;
  logic                      phase_we, pos_we;
  logic                      accept, out_free;

  ring_req_t        ring_req;
  slot_t            ring_rd;
  logic             ring_ready;
  logic [ACC_W-1:0] add_l, add_r;

  msmix_ring u_ring (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .req_i     (ring_req),
    .rd_data_o (ring_rd),
    .ready_o   (ring_ready)
  );

  msmix_scale u_scale (
    .clk_i       (clk_i),
    .muted_i     (muted_q),
    .gain_i      (gain_q),
    .left_i      (left_q),
    .right_i     (right_q),
    .add_left_o  (add_l),
    .add_right_o (add_r)
  );

  assign in_ready_o = state_q[0] && ring_ready;
  assign accept     = in_valid_i && in_ready_o;
  assign out_free   = !out_vld_q || out_ready_i;
  assign idx        = src_q[SRC_IDX_W-1:0];
  assign relocate   = fob_q && ((pos_q[idx] < rp_q) || (pos_q[idx] > bound_q));
  assign step_sum   = {{(STEP_W-PHASE_W+1){1'b0}}, cur_phase_q} + {1'b0, rate_q[idx]};

  always_comb begin
    state_d     = state_q;
    rp_d        = rp_q;
    bound_d     = bound_q;
    lead_d      = lead_q;
    cur_pos_d   = cur_pos_q;
    cur_phase_d = cur_phase_q;
    cnt_d       = cnt_q;
    wr_pend_d   = wr_pend_q;
    wr_addr_d   = wr_addr_q;
    phase_we    = 1'b0;
    pos_we      = 1'b0;
    out_load    = 1'b0;
    ring_req    = '0;

    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if (kind_i) begin
            ring_req.rd_en   = 1'b1;
            ring_req.rd_addr = rp_q[RING_AW-1:0];
            state_d          = ST_DR_CLR;
          end else begin
            state_d = ST_CHECK;
          end
        end
      end
      ST_CHECK: begin
        if (src_q >= SRC_W'(SOURCES)) begin
          state_d = ST_IDLE;
        end else begin
          cur_pos_d   = relocate ? lead_q : pos_q[idx];
          cur_phase_d = relocate ? '0 : phase_q[idx];
          state_d     = ST_STEP;
        end
      end
      ST_STEP: begin
        cnt_d     = step_sum[STEP_W:PHASE_W];
        phase_we  = 1'b1;
        wr_pend_d = 1'b0;
        state_d   = ST_MIX;
      end
      ST_MIX: begin
        if (wr_pend_q) begin
          ring_req.wr_en        = 1'b1;
          ring_req.wr_addr      = wr_addr_q;
          ring_req.wr_data.left  = ring_rd.left + add_l;
          ring_req.wr_data.right = ring_rd.right + add_r;
        end
        if (cnt_q != '0) begin
          ring_req.rd_en   = 1'b1;
          ring_req.rd_addr = cur_pos_q[RING_AW-1:0];
          wr_addr_d        = cur_pos_q[RING_AW-1:0];
          wr_pend_d        = 1'b1;
          cur_pos_d        = cur_pos_q + 1'b1;
          cnt_d            = cnt_q - 1'b1;
        end else begin
          wr_pend_d = 1'b0;
          pos_we    = 1'b1;
          state_d   = ST_IDLE;
        end
      end
      ST_DR_CLR: begin
        ring_req.wr_en   = 1'b1;
        ring_req.wr_addr = rp_q[RING_AW-1:0];
        rp_d             = rp_q + 1'b1;
        bound_d          = bound_q + 1'b1;
        lead_d           = lead_q + 1'b1;
        if (out_free) begin
          out_load = 1'b1;
          state_d  = ST_IDLE;
        end else begin
          state_d = ST_DR_OUT;
        end
      end
      ST_DR_OUT: begin
        if (out_free) begin
          out_load = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase

    out_vld_d = out_load || (out_vld_q && !out_ready_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      muted_q   <= 1'b0;
      gain_q    <= GAIN_RESET;
      rp_q      <= '0;
      bound_q   <= POS_W'(RING_DEPTH - GUARD_FRAMES);
      lead_q    <= POS_W'(LEAD_FRAMES);
      cnt_q     <= '0;
      wr_pend_q <= 1'b0;
      out_vld_q <= 1'b0;
      for (int i = 0; i < NUM_RATE; i++) begin
        rate_q[i] <= STEP_RESET;
      end
      for (int i = 0; i < SOURCES; i++) begin
        pos_q[i]   <= '0;
        phase_q[i] <= '0;
      end
    end else begin
      state_q   <= state_d;
      rp_q      <= rp_d;
      bound_q   <= bound_d;
      lead_q    <= lead_d;
      cnt_q     <= cnt_d;
      wr_pend_q <= wr_pend_d;
      out_vld_q <= out_vld_d;
      if (phase_we) begin
        phase_q[idx] <= step_sum[PHASE_W-1:0];
      end
      if (pos_we) begin
        pos_q[idx] <= cur_pos_q;
      end
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CFG_MUTED: muted_q <= cfg_wdata_i[0];
          CFG_GAIN:  gain_q  <= cfg_wdata_i[GAIN_W-1:0];
          default:   rate_q[SRC_IDX_W'(cfg_idx_i - CFG_RATE0)] <= cfg_wdata_i[STEP_W-1:0];
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      src_q   <= source_id_i;
      fob_q   <= first_of_buffer_i;
      left_q  <= left_in_i;
      right_q <= right_in_i;
    end
    cur_pos_q   <= cur_pos_d;
    cur_phase_q <= cur_phase_d;
    wr_addr_q   <= wr_addr_d;
    if (out_load) begin
      out_l_q <= sat16(ring_rd.left);
      out_r_q <= sat16(ring_rd.right);
    end
  end

  assign out_valid_o = out_vld_q;
  assign left_out_o  = out_l_q;
  assign right_out_o = out_r_q;

endmodule
